FILE: sv/spi_register_access_master_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial register-access master
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPI_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define SPI_REGISTER_ACCESS_MASTER_ASSERT_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define SRAM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SRAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRAM_ASSERT_ALWAYS(label, cond, msg)
`define SRAM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: sv/spi_ram_pkg.sv
// ----------------------------------------------------------------------------
// spi_ram_pkg
// Constants and codes for the serial register-access master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spi_ram_pkg;

    localparam int ADDR_BITS     = 7;
    localparam int MAX_DATA_BITS = 32;
    localparam int CNT_W         = 6;
    localparam int FRAME_W       = 1 + ADDR_BITS + MAX_DATA_BITS;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_WRITE = 2'd0;
    localparam func_t FUNC_READ  = 2'd1;
    localparam func_t FUNC_TICK  = 2'd2;

endpackage

FILE: sv/spi_register_access_master.sv
// ----------------------------------------------------------------------------
// spi_register_access_master
// Serial register-access master: read/write bit, address, data, MSB first.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------
//  in      | in_valid / in_stall         | func, reg_address, write_word,
//          |                             | bit_count, miso_level
//  out     | out_valid / out_stall       | chip_select_n, mosi_level,
//          |                             | clock_pulse, frame_done, read_word,
//          |                             | start_rejected
//
//  One transaction per clock unless stalled; its result is in the output
//  register on the next cycle. Frame state and output register update as one.
//  The input stalls only while a result sits in the output register and the
//  output side stalls. Reset idles the frame and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "spi_register_access_master_assert.svh"

module spi_register_access_master
    import spi_ram_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  func_t                func,
    input  logic [ADDR_BITS-1:0] reg_address,
    input  logic [31:0]          write_word,
    input  logic [CNT_W-1:0]     bit_count,
    input  logic                 miso_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 chip_select_n,
    output logic                 mosi_level,
    output logic                 clock_pulse,
    output logic                 frame_done,
    output logic [31:0]          read_word,
    output logic                 start_rejected
);

    // frame state
    logic                     busy_reg, busy_next;
    logic                     is_read_reg, is_read_next;
    logic [CNT_W-1:0]         bits_left_reg, bits_left_next;
    logic [CNT_W-1:0]         data_count_reg, data_count_next;
    logic [FRAME_W-1:0]       tx_reg, tx_next;
    logic [MAX_DATA_BITS-1:0] rx_reg, rx_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic                     cs_n_reg, cs_n_next;
    logic                     mosi_reg, mosi_next;
    logic                     pulse_reg, pulse_next;
    logic                     done_reg, done_next;
    logic [31:0]              rword_reg, rword_next;
    logic                     rej_reg, rej_next;

    logic                     in_fire;
    logic [CNT_W-1:0]         cnt_sat;
    logic [CNT_W-1:0]         align_shift;
    logic [MAX_DATA_BITS-1:0] data_aligned;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        if (bit_count == '0)
            cnt_sat = CNT_W'(1);
        else if (bit_count > CNT_W'(MAX_DATA_BITS))
            cnt_sat = CNT_W'(MAX_DATA_BITS);
        else
            cnt_sat = bit_count;
        align_shift  = CNT_W'(MAX_DATA_BITS) - cnt_sat;
        // left-justify the data so the first data bit lands at the top
        data_aligned = write_word << align_shift[4:0];
    end

    always_comb
    begin
        busy_next       = busy_reg;
        is_read_next    = is_read_reg;
        bits_left_next  = bits_left_reg;
        data_count_next = data_count_reg;
        tx_next         = tx_reg;
        rx_next         = rx_reg;
        cs_n_next       = ~busy_reg;
        mosi_next       = 1'b0;
        pulse_next      = 1'b0;
        done_next       = 1'b0;
        rword_next      = '0;
        rej_next        = 1'b0;

        unique case (func) inside
            FUNC_WRITE, FUNC_READ:
            begin
                if (busy_reg)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    busy_next       = 1'b1;
                    is_read_next    = func[0];
                    bits_left_next  = CNT_W'(1 + ADDR_BITS) + cnt_sat;
                    data_count_next = cnt_sat;
                    rx_next         = '0;
                    cs_n_next       = 1'b0;
                    // read frames hold the last address bit through the data phase
                    if (func[0])
                        tx_next = {func[0], reg_address, {MAX_DATA_BITS{reg_address[0]}}};
                    else
                        tx_next = {func[0], reg_address, data_aligned};
                end
            end
            FUNC_TICK:
            begin
                if (busy_reg)
                begin
                    mosi_next      = tx_reg[FRAME_W-1];
                    tx_next        = {tx_reg[FRAME_W-2:0], 1'b0};
                    pulse_next     = 1'b1;
                    cs_n_next      = 1'b0;
                    bits_left_next = bits_left_reg - CNT_W'(1);
                    if (is_read_reg && bits_left_reg <= data_count_reg)
                        rx_next = {rx_reg[MAX_DATA_BITS-2:0], miso_level};
                    if (bits_left_reg == CNT_W'(1))
                    begin
                        done_next = 1'b1;
                        cs_n_next = 1'b1;
                        busy_next = 1'b0;
                        if (is_read_reg)
                            rword_next = rx_next;
                    end
                end
            end
            default:
            begin
                cs_n_next = ~busy_reg;
            end
        endcase
    end

    assign out_valid_next = in_fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            is_read_reg    <= 1'b0;
            bits_left_reg  <= '0;
            data_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                busy_reg       <= busy_next;
                is_read_reg    <= is_read_next;
                bits_left_reg  <= bits_left_next;
                data_count_reg <= data_count_next;
            end
        end
    end

    // shift registers and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            cs_n_reg  <= cs_n_next;
            mosi_reg  <= mosi_next;
            pulse_reg <= pulse_next;
            done_reg  <= done_next;
            rword_reg <= rword_next;
            rej_reg   <= rej_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chip_select_n  = cs_n_reg;
    assign mosi_level     = mosi_reg;
    assign clock_pulse    = pulse_reg;
    assign frame_done     = done_reg;
    assign read_word      = rword_reg;
    assign start_rejected = rej_reg;

    `SRAM_ASSERT_ALWAYS(a_busy_count, !busy_reg || (bits_left_reg != '0 && bits_left_reg <= CNT_W'(FRAME_W)), "busy frame with bad bit count")
    `SRAM_ASSERT_ALWAYS(a_stall_needs_result, !in_stall || out_valid_reg, "input stalled with empty output register")
    `SRAM_ASSERT_ALWAYS(a_done_shape, !(out_valid_reg && done_reg) || (pulse_reg && cs_n_reg && !rej_reg), "frame_done without pulse and released select")
    `SRAM_ASSERT_NEXT(a_last_tick_idles, in_fire && busy_reg && func == FUNC_TICK && bits_left_reg == CNT_W'(1), !busy_reg && done_reg, "last tick did not close the frame")
    `SRAM_ASSERT_NEXT(a_reject_keeps_frame, in_fire && busy_reg && (func == FUNC_WRITE || func == FUNC_READ), busy_reg && $stable(bits_left_reg) && rej_reg, "rejected start disturbed the frame")

endmodule

FILE: tb/tb_spi_register_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_register_access_master
// Sends write, read, tick and unused-code transactions to the serial
// register-access master. Both channels idle at random, with quiet stretches.
// A scoreboard class tracks the frame state and checks every result field.
// ----------------------------------------------------------------------------

module tb_spi_register_access_master;
    import spi_ram_pkg::*;

    localparam func_t FUNC_UNUSED  = 2'd3;
    localparam int    CLK_HALF     = 6;
    localparam int    RANDOM_ITEMS = 700;
    localparam int    HOLD_CYCLES  = 120;
    localparam int    SETTLE       = 8;

    typedef struct packed {
        logic        chip_select_n;
        logic        mosi_level;
        logic        clock_pulse;
        logic        frame_done;
        logic [31:0] read_word;
        logic        start_rejected;
    } serial_beat_t;

    class frame_scoreboard;
        bit                   busy;
        bit                   is_read;
        int                   bits_sent;
        int                   frame_len;
        int                   data_bits;
        logic [31:0]          tx_word;
        logic [31:0]          rx_word;
        logic [ADDR_BITS-1:0] address;
        serial_beat_t         pending_beats[$];
        int                   errors;

        function new();
            busy      = 1'b0;
            is_read   = 1'b0;
            bits_sent = 0;
            frame_len = 0;
            data_bits = 0;
            tx_word   = '0;
            rx_word   = '0;
            address   = '0;
            errors    = 0;
        endfunction

        function logic [31:0] low_mask(int n);
            if (n >= 32)
                return '1;
            return (32'd1 << n) - 32'd1;
        endfunction

        function bit frame_open();
            return busy;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        // Advance the frame state by one accepted transaction and queue its result.
        function void note_transaction(func_t f, logic [ADDR_BITS-1:0] addr,
                                       logic [31:0] wword, logic [CNT_W-1:0] cnt,
                                       logic miso);
            serial_beat_t want;
            int           k;
            want = '0;
            want.chip_select_n = !busy;
            if (f == FUNC_WRITE || f == FUNC_READ) begin
                if (busy) begin
                    want.start_rejected = 1'b1;
                end
                else begin
                    data_bits = (cnt == 0) ? 1 :
                                ((cnt > MAX_DATA_BITS) ? MAX_DATA_BITS : int'(cnt));
                    busy      = 1'b1;
                    is_read   = (f == FUNC_READ);
                    bits_sent = 0;
                    frame_len = 1 + ADDR_BITS + data_bits;
                    tx_word   = wword & low_mask(data_bits);
                    address   = addr;
                    rx_word   = '0;
                    want.chip_select_n = 1'b0;
                end
            end
            else if (f == FUNC_TICK && busy) begin
                k = bits_sent;
                if (k == 0) begin
                    want.mosi_level = is_read;
                end
                else if (k <= ADDR_BITS) begin
                    want.mosi_level = address[ADDR_BITS - k];
                end
                else if (is_read) begin
                    // mosi holds the last address bit while data shifts in
                    want.mosi_level = address[0];
                    rx_word = ((rx_word << 1) | {31'd0, miso}) & low_mask(data_bits);
                end
                else begin
                    want.mosi_level = tx_word[data_bits - 1 - (k - 1 - ADDR_BITS)];
                end
                want.clock_pulse   = 1'b1;
                want.chip_select_n = 1'b0;
                bits_sent = k + 1;
                if (bits_sent >= frame_len) begin
                    want.frame_done    = 1'b1;
                    want.chip_select_n = 1'b1;
                    busy = 1'b0;
                    if (is_read)
                        want.read_word = rx_word;
                end
            end
            pending_beats.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_output(serial_beat_t got);
            serial_beat_t want;
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_beats.pop_front();
            compare_field("chip_select_n", 32'(want.chip_select_n), 32'(got.chip_select_n));
            compare_field("mosi_level", 32'(want.mosi_level), 32'(got.mosi_level));
            compare_field("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare_field("read_word", want.read_word, got.read_word);
            compare_field("start_rejected", 32'(want.start_rejected),
                          32'(got.start_rejected));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    func_t                func;
    logic [ADDR_BITS-1:0] reg_address;
    logic [31:0]          write_word;
    logic [CNT_W-1:0]     bit_count;
    logic                 miso_level;
    logic                 out_valid;
    logic                 out_stall;
    logic                 chip_select_n;
    logic                 mosi_level;
    logic                 clock_pulse;
    logic                 frame_done;
    logic [31:0]          read_word;
    logic                 start_rejected;

    frame_scoreboard sb;
    int              items_sent;
    bit              tx_quiet;
    bit              rx_quiet;
    bit              hold_req;

    spi_register_access_master uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .reg_address    (reg_address),
        .write_word     (write_word),
        .bit_count      (bit_count),
        .miso_level     (miso_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chip_select_n  (chip_select_n),
        .mosi_level     (mosi_level),
        .clock_pulse    (clock_pulse),
        .frame_done     (frame_done),
        .read_word      (read_word),
        .start_rejected (start_rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CNT_W'($urandom_range(33, 63));
        if (r == 2)
            return CNT_W'($urandom_range(9, 32));
        if (r == 3)
            return CNT_W'(MAX_DATA_BITS);
        return CNT_W'($urandom_range(1, 8));
    endfunction

    task automatic send_item(func_t f, logic [ADDR_BITS-1:0] addr, logic [31:0] wword,
                             logic [CNT_W-1:0] cnt, logic miso);
        int gap;
        gap = (!tx_quiet && $urandom_range(0, 2) == 0) ? pick_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= f;
        reg_address <= addr;
        write_word  <= wword;
        bit_count   <= cnt;
        miso_level  <= miso;
        do
            @(posedge clk);
        while (in_stall);
        // idle ticks and the unused code do not advance the frame
        if (f != FUNC_UNUSED && (f != FUNC_TICK || sb.frame_open()))
            items_sent++;
        sb.note_transaction(f, addr, wword, cnt, miso);
    endtask

    task automatic send_random(func_t f, logic [CNT_W-1:0] cnt);
        logic [ADDR_BITS-1:0] a;
        logic [31:0]          w;
        logic                 m;
        a = ADDR_BITS'($urandom);
        w = $urandom;
        m = 1'($urandom);
        send_item(f, a, w, cnt, m);
    endtask

    task automatic run_frame(bit noisy);
        func_t f;
        f = ($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE;
        send_random(f, pick_count());
        while (sb.frame_open())
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_random(func_t'($urandom_range(0, 3)), CNT_W'($urandom));
            else
                send_random(FUNC_TICK, CNT_W'($urandom));
        end
        if (noisy && $urandom_range(0, 3) == 0)
            send_random(func_t'($urandom_range(0, 3)), pick_count());
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_len() - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        serial_beat_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                seen.chip_select_n  = chip_select_n;
                seen.mosi_level     = mosi_level;
                seen.clock_pulse    = clock_pulse;
                seen.frame_done     = frame_done;
                seen.read_word      = read_word;
                seen.start_rejected = start_rejected;
                sb.check_output(seen);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("tb_spi_register_access_master: done, errors");
        $finish;
    end

    initial
    begin
        int  base;
        bit  hold_done;
        bit  drain_done;
        sb          = new();
        items_sent  = 0;
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b1;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        drain_done  = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_TICK;
        reg_address = '0;
        write_word  = '0;
        bit_count   = '0;
        miso_level  = 1'b0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tick and unused code with no frame open
        send_item(FUNC_TICK, '0, '0, '0, 1'b1);
        send_item(FUNC_UNUSED, '1, '1, '1, 1'b1);
        // zero count widens to one data bit
        send_item(FUNC_WRITE, '1, 32'hFFFF_FFFF, '0, 1'b0);
        // start and unused code while the frame is open
        send_item(FUNC_READ, '0, '0, '1, 1'b1);
        send_item(FUNC_UNUSED, '0, '0, '0, 1'b0);
        repeat (9) send_item(FUNC_TICK, '0, '0, '0, 1'b0);
        send_item(FUNC_READ, '0, 32'hFFFF_FFFF, 6'd1, 1'b0);
        repeat (9) send_item(FUNC_TICK, '1, '1, '1, 1'b1);

        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        base     = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!hold_done && items_sent - base > 250) begin
                // back-to-back ticks against a stalled receiver fill the block
                hold_done = 1'b1;
                tx_quiet  = 1'b1;
                hold_req  = 1'b1;
                run_frame(1'b0);
            end
            else if (!drain_done && items_sent - base > 450) begin
                drain_done = 1'b1;
                // drop valid so the last transaction is not taken again
                @(negedge clk);
                in_valid <= 1'b0;
                wait_drained();
                run_frame(1'b1);
            end
            else begin
                run_frame($urandom_range(0, 4) != 0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_spi_register_access_master: done, clean");
        else
            $display("tb_spi_register_access_master: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/spi_ram_pkg.sv
sv/spi_register_access_master.sv
tb/tb_spi_register_access_master.sv
